[rtl/srdiv_pkg.sv]
package srdiv_pkg;

	localparam int SRD_NW    = 64;
	localparam int SRD_QW    = 32;
	localparam int SRD_SW    = 6;
	localparam int SRD_DW    = SRD_NW + SRD_QW;
	localparam int SRD_STEPS = SRD_QW;
	localparam int SRD_LATENCY = SRD_STEPS + 3;

	localparam logic [SRD_SW-1:0] SRD_MAX_SHIFT = SRD_SW'(32);
	localparam logic [SRD_QW-1:0] SRD_QMAX      = '1;

	typedef struct packed {
		logic valid;
		logic serr;
		logic zero;
		logic big;
	} srdiv_ctl_t;

	typedef struct packed {
		srdiv_ctl_t              ctl;
		logic [SRD_NW-1:0]       rem;
		logic [SRD_QW-1:0]       lq;
		logic [SRD_NW-1:0]       dvs;
	} srdiv_stage_t;

endpackage

[rtl/srdiv_front.sv]
module srdiv_front
	import srdiv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SRD_NW-1:0]    numerator,
	input  logic [SRD_NW-1:0]    divisor,
	input  logic [SRD_SW-1:0]    shift_amount,
	output srdiv_stage_t         stage_out
);

	srdiv_ctl_t          ctl_s1;
	logic [SRD_DW-1:0]   dvd_s1;
	logic [SRD_NW-1:0]   dvs_s1;
	srdiv_ctl_t          ctl_s2;
	logic [SRD_NW-1:0]   rem_s2;
	logic [SRD_QW-1:0]   lq_s2;
	logic [SRD_NW-1:0]   dvs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.serr  <= shift_amount > SRD_MAX_SHIFT;
			ctl_s1.zero  <= divisor == '0;
			ctl_s1.big   <= 1'b0;
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.serr  <= ctl_s1.serr;
			ctl_s2.zero  <= ctl_s1.zero;
			ctl_s2.big   <= dvd_s1[SRD_DW-1:SRD_QW] >= dvs_s1;
		end
	end

	// The quotient fits in 32 bits only when the upper 64 dividend bits are below the divisor.
	always_ff @(posedge clk) begin
		dvd_s1 <= {{SRD_QW{1'b0}}, numerator} << shift_amount;
		dvs_s1 <= divisor;
		rem_s2 <= dvd_s1[SRD_DW-1:SRD_QW];
		lq_s2  <= dvd_s1[SRD_QW-1:0];
		dvs_s2 <= dvs_s1;
	end

	assign stage_out = {ctl_s2, rem_s2, lq_s2, dvs_s2};

endmodule

[rtl/srdiv_step.sv]
module srdiv_step
	import srdiv_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  srdiv_stage_t  stage_in,
	output srdiv_stage_t  stage_out
);

	logic [SRD_NW:0]   trial;
	logic [SRD_NW:0]   diff;
	logic              ge;
	srdiv_ctl_t        ctl_s1;
	logic [SRD_NW-1:0] rem_s1;
	logic [SRD_QW-1:0] lq_s1;
	logic [SRD_NW-1:0] dvs_s1;

	always_comb begin
		trial = {stage_in.rem, stage_in.lq[SRD_QW-1]};
		diff  = trial - {1'b0, stage_in.dvs};
		ge    = trial >= {1'b0, stage_in.dvs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= stage_in.ctl;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= ge ? diff[SRD_NW-1:0] : trial[SRD_NW-1:0];
		lq_s1  <= {stage_in.lq[SRD_QW-2:0], ge};
		dvs_s1 <= stage_in.dvs;
	end

	assign stage_out = {ctl_s1, rem_s1, lq_s1, dvs_s1};

endmodule

[rtl/srdiv_round.sv]
module srdiv_round
	import srdiv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  srdiv_stage_t         stage_in,
	output logic                 done,
	output logic [SRD_QW-1:0]    quotient,
	output logic                 overflow,
	output logic                 shift_error
);

	logic            half_up;
	logic [SRD_QW:0] sum;

	always_comb begin
		half_up = {stage_in.rem, 1'b0} >= {1'b0, stage_in.dvs};
		sum     = {1'b0, stage_in.lq} + (SRD_QW + 1)'(half_up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= stage_in.ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_in.ctl.serr) begin
			quotient    <= '0;
			overflow    <= 1'b0;
			shift_error <= 1'b1;
		end else if (stage_in.ctl.zero) begin
			quotient    <= '0;
			overflow    <= 1'b0;
			shift_error <= 1'b0;
		end else if (stage_in.ctl.big || sum[SRD_QW]) begin
			quotient    <= SRD_QMAX;
			overflow    <= 1'b1;
			shift_error <= 1'b0;
		end else begin
			quotient    <= sum[SRD_QW-1:0];
			overflow    <= 1'b0;
			shift_error <= 1'b0;
		end
	end

endmodule

[rtl/scaled_rounding_divide_sat32.sv]
// Scaled rounding divider with 32-bit saturation.
// A transaction is taken at each rising edge where start is high and busy is low.
// Busy is always low, so a new transaction may be started in every cycle.
// The numerator is shifted left by shift_amount to a 96-bit dividend and divided
// by the divisor; the quotient is rounded half up and saturated to 32 bits.
// Each result appears on quotient, overflow and shift_error for exactly one cycle,
// marked by done. The front block shifts the dividend and tests for overflow, a chain
// of 32 divider stages finds one quotient bit per stage, and a last stage rounds.
// Throughput is one transaction per cycle.
// Results leave in the order their transactions were taken.
// The receiver cannot stall the block; it must take each result when done is high.
// Reset clears all in-flight transactions, and done stays low until new ones
// have passed through the pipeline.
module scaled_rounding_divide_sat32
	import srdiv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [SRD_NW-1:0]    numerator,
	input  logic [SRD_NW-1:0]    divisor,
	input  logic [SRD_SW-1:0]    shift_amount,
	output logic                 done,
	output logic [SRD_QW-1:0]    quotient,
	output logic                 overflow,
	output logic                 shift_error
);

	srdiv_stage_t chain [0:SRD_STEPS];

	assign busy = 1'b0;

	srdiv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.numerator    (numerator),
		.divisor      (divisor),
		.shift_amount (shift_amount),
		.stage_out    (chain[0])
	);

	for (genvar g = 0; g < SRD_STEPS; g++) begin : g_step
		srdiv_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (chain[g]),
			.stage_out (chain[g+1])
		);
	end

	srdiv_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage_in    (chain[SRD_STEPS]),
		.done        (done),
		.quotient    (quotient),
		.overflow    (overflow),
		.shift_error (shift_error)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##SRD_LATENCY done)
		else $error("result did not appear at the expected latency");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(overflow && shift_error))
		else $error("overflow and shift error raised together");

	a_shift_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && shift_error) |-> (quotient == '0))
		else $error("shift error with nonzero quotient");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (quotient == SRD_QMAX))
		else $error("overflow without saturated quotient");

endmodule

[dv/srdiv_checker.sv]
module srdiv_checker
	import srdiv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [SRD_NW-1:0] numerator,
	input  logic [SRD_NW-1:0] divisor,
	input  logic [SRD_SW-1:0] shift_amount,
	input  logic              done,
	input  logic [SRD_QW-1:0] quotient,
	input  logic              overflow,
	input  logic              shift_error,
	output int                fails,
	output int                pending
);

	typedef struct packed {
		logic [SRD_QW-1:0] q;
		logic              ovf;
		logic              serr;
	} div_res_t;

	div_res_t quot_due[$];
	div_res_t want;

	function automatic div_res_t predict_div(input logic [SRD_NW-1:0] num,
			input logic [SRD_NW-1:0] den, input logic [SRD_SW-1:0] sh);
		div_res_t res;
		logic [SRD_DW:0] dividend;
		logic [SRD_DW:0] quo;
		logic [SRD_DW:0] rem;
		logic [SRD_DW:0] den_w;
		res = '0;
		den_w = {{(SRD_DW+1-SRD_NW){1'b0}}, den};
		if (sh > SRD_MAX_SHIFT) begin
			res.serr = 1'b1;
		end else if (den != '0) begin
			dividend = {{(SRD_DW+1-SRD_NW){1'b0}}, num} << sh;
			quo = dividend / den_w;
			rem = dividend % den_w;
			if ((rem << 1) >= den_w) begin
				quo = quo + 1'b1;
			end
			if (quo > {{(SRD_DW+1-SRD_QW){1'b0}}, SRD_QMAX}) begin
				res.q = SRD_QMAX;
				res.ovf = 1'b1;
			end else begin
				res.q = quo[SRD_QW-1:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (quot_due.size() == 0) begin
					if (fails < 10) begin
						$display("unexpected result: quotient %h overflow %b shift_error %b",
							quotient, overflow, shift_error);
					end
					fails++;
				end else begin
					want = quot_due.pop_front();
					if (quotient !== want.q || overflow !== want.ovf ||
							shift_error !== want.serr) begin
						if (fails < 10) begin
							$display("mismatch: expected %h/%b/%b, got %h/%b/%b",
								want.q, want.ovf, want.serr,
								quotient, overflow, shift_error);
						end
						fails++;
					end
				end
			end
			if (start && !busy) begin
				quot_due.push_back(predict_div(numerator, divisor, shift_amount));
			end
			pending = quot_due.size();
		end
	end

endmodule

[dv/tb_top.sv]
module tb_top;
	import srdiv_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [SRD_NW-1:0] numerator;
	logic [SRD_NW-1:0] divisor;
	logic [SRD_SW-1:0] shift_amount;
	logic              done;
	logic [SRD_QW-1:0] quotient;
	logic              overflow;
	logic              shift_error;
	int                fails;
	int                pending;
	int                cycles;

	scaled_rounding_divide_sat32 u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.numerator    (numerator),
		.divisor      (divisor),
		.shift_amount (shift_amount),
		.done         (done),
		.quotient     (quotient),
		.overflow     (overflow),
		.shift_error  (shift_error)
	);

	srdiv_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.numerator    (numerator),
		.divisor      (divisor),
		.shift_amount (shift_amount),
		.done         (done),
		.quotient     (quotient),
		.overflow     (overflow),
		.shift_error  (shift_error),
		.fails        (fails),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		cycles = 0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic issue(input logic [63:0] n, input logic [63:0] d, input logic [5:0] s);
		start <= 1'b1;
		numerator <= n;
		divisor <= d;
		shift_amount <= s;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic rest(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Most items size the divisor against the shifted numerator so that quotients
	// spread over every width up to just past 32 bits.
	task automatic rand_item(output logic [63:0] n, output logic [63:0] d,
			output logic [5:0] s);
		int kind;
		int nb;
		int qb;
		int db;
		kind = $urandom_range(0, 99);
		n = rand64();
		d = rand64();
		s = 6'($urandom);
		if (kind < 10) begin
			return;
		end
		if (kind < 15) begin
			s = 6'($urandom_range(33, 63));
			return;
		end
		s = 6'($urandom_range(0, 32));
		if (kind < 18) begin
			d = '0;
			return;
		end
		nb = $urandom_range(1, 64);
		n = n >> (64 - nb);
		n[nb-1] = 1'b1;
		qb = $urandom_range(0, 34);
		db = nb + int'(s) - qb;
		if (db < 1) begin
			db = 1;
		end
		if (db > 64) begin
			db = 64;
		end
		d = d >> (64 - db);
		d[db-1] = 1'b1;
	endtask

	initial begin : stim
		logic [63:0] n;
		logic [63:0] d;
		logic [5:0]  s;
		int          burst;
		arst_n = 1'b0;
		start = 1'b0;
		numerator = '0;
		divisor = '0;
		shift_amount = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue('0, '0, 6'd0);
		issue('1, '0, 6'd33);
		issue('1, '1, 6'd63);
		issue(64'd5, '0, 6'd32);
		issue('0, 64'd1, 6'd0);
		issue('1, '1, 6'd0);
		issue('1, 64'd1, 6'd0);
		issue('1, '1, 6'd32);
		issue(64'h1234_5678_9abc_def0, 64'h1234_5678_9abc_def0, 6'd31);
		issue(64'h1_ffff_ffff, 64'd2, 6'd0);
		issue(64'h2_ffff_fffe, 64'd3, 6'd0);
		issue(64'h0000_0000_ffff_ffff, 64'd1, 6'd0);
		issue(64'd1, 64'd2, 6'd0);
		issue(64'd1, 64'd3, 6'd0);
		issue(64'h8000_0000_0000_0000, '1, 6'd0);
		issue(64'h7fff_ffff_ffff_ffff, '1, 6'd0);
		issue(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 6'd32);
		issue(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 6'd16);
		issue(64'd3, 64'h0000_0000_0000_0007, 6'd32);
		issue('1, 64'h8000_0000_0000_0000, 6'd32);
		issue('1, 64'h8000_0000_0000_0001, 6'd31);
		issue(64'd1, 64'h1_0000_0000, 6'd32);
		drain();

		burst = $urandom_range(1, 40);
		for (int i = 0; i < 1050; i++) begin
			if (i == 500) begin
				drain();
			end
			rand_item(n, d, s);
			issue(n, d, s);
			burst--;
			if (burst == 0) begin
				if ($urandom_range(0, 3) != 0) begin
					rest($urandom_range(1, 12));
				end
				burst = $urandom_range(1, 40);
			end
		end

		drain();
		repeat (SRD_LATENCY + 5) @(posedge clk);
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[scaled_rounding_divide_sat32.f]
rtl/srdiv_pkg.sv
rtl/srdiv_front.sv
rtl/srdiv_step.sv
rtl/srdiv_round.sv
rtl/scaled_rounding_divide_sat32.sv
dv/srdiv_checker.sv
dv/tb_top.sv
